[hw/rtl/ehwc_pkg.sv]
// ----------------------------------------------------------------------------
// ehwc_pkg
// Shared types, constants and codes of the ELF hash word counter.
// ----------------------------------------------------------------------------
package ehwc_pkg;

    localparam int CH_W        = 8;
    localparam int HASH_W      = 28;
    localparam int CFG_W       = 11;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 16;
    localparam int DIV_STEPS   = HASH_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_LEN_DEF     = 16;

    localparam logic [CFG_W-1:0]   TABLE_SIZE_RST = CFG_W'(1021);
    localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TABLE_SIZE = '0;

    typedef enum logic [STATUS_W-1:0] {
        STAT_COUNTED  = 3'd0,
        STAT_INSERTED = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_TOO_LONG = 3'd3,
        STAT_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_LOAD,
        S_DIV,
        S_CHECK,
        S_PROBE_RD,
        S_PROBE_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic byte_take;
        logic div_load;
        logic div_step;
        logic probe_load;
        logic probe_read;
        logic probe_eval;
        logic pend_special;
        logic res_load;
        logic word_clear;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic word_empty;
        logic word_long;
        logic slot_free;
        logic slot_hit;
        logic probe_last;
        logic out_busy;
    } sts_t;

endpackage

[hw/rtl/ehwc_byte_if.sv]
// ----------------------------------------------------------------------------
// ehwc_byte_if
// Byte stream channel: one character and a last-byte mark per transaction.
// ----------------------------------------------------------------------------
interface ehwc_byte_if;
    logic                        valid;
    logic                        ready;
    logic [ehwc_pkg::CH_W-1:0]   ch;
    logic                        last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

[hw/rtl/ehwc_result_if.sv]
// ----------------------------------------------------------------------------
// ehwc_result_if
// Result channel: status, slot and count per closed word.
// ----------------------------------------------------------------------------
interface ehwc_result_if;
    logic                           valid;
    logic                           ready;
    logic [ehwc_pkg::STATUS_W-1:0]  status;
    logic [ehwc_pkg::SLOT_W-1:0]    slot;
    logic [ehwc_pkg::COUNT_W-1:0]   count;

    modport source (output valid, output status, output slot, output count, input ready);
    modport sink   (input valid, input status, input slot, input count, output ready);
endinterface

[hw/rtl/elf_hash_word_counter.sv]
// ----------------------------------------------------------------------------
// elf_hash_word_counter
// Word frequency counter over a linear-probing table keyed by the ELF hash.
// ----------------------------------------------------------------------------
// Non-closing bytes are taken in the idle state. A closing byte is taken, then
// the divider is loaded, the hash remainder is computed bit-serially, the word
// is checked, and each probed slot is read and then compared through the read
// port of the table RAM; the result is then handed to the output register once
// that register is free. An empty or over-long word skips the probe walk. After
// reset all TABLE_DEPTH table entries are cleared, during which no byte is
// taken; the table_size register is writable throughout.
module elf_hash_word_counter #(
    parameter int TABLE_DEPTH = ehwc_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_LEN     = ehwc_pkg::MAX_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ehwc_byte_if.sink                       bytes,
    ehwc_result_if.source                   results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ehwc_pkg::PADDR_W-1:0]    paddr,
    input  logic [ehwc_pkg::PDATA_W-1:0]    pwdata,
    output logic [ehwc_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    logic [ehwc_pkg::CFG_W-1:0] table_size_reg;
    logic                       reg_hit;
    ehwc_pkg::cmd_t             cmd;
    ehwc_pkg::sts_t             sts;

    assign reg_hit = (paddr[ehwc_pkg::PADDR_W-1:2] == ehwc_pkg::REG_TABLE_SIZE);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? ehwc_pkg::PDATA_W'(table_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= ehwc_pkg::TABLE_SIZE_RST;
        end
        else if (psel && penable && pwrite && reg_hit)
        begin
            table_size_reg <= pwdata[ehwc_pkg::CFG_W-1:0];
        end
    end

    ehwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_last  (bytes.last),
        .in_ready (bytes.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ehwc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_LEN     (MAX_LEN)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .table_size (table_size_reg),
        .ch         (bytes.ch),
        .out_ready  (results.ready),
        .out_valid  (results.valid),
        .out_status (results.status),
        .out_slot   (results.slot),
        .out_count  (results.count)
    );

endmodule

[hw/rtl/ehwc_ram.sv]
// ----------------------------------------------------------------------------
// ehwc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ehwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/ehwc_datapath.sv]
// ----------------------------------------------------------------------------
// ehwc_datapath
// Word buffer, ELF hash, remainder divider, slot table and result register.
// ----------------------------------------------------------------------------
module ehwc_datapath #(
    parameter int TABLE_DEPTH = ehwc_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_LEN     = ehwc_pkg::MAX_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ehwc_pkg::cmd_t                    cmd,
    output ehwc_pkg::sts_t                    sts,
    input  logic [ehwc_pkg::CFG_W-1:0]        table_size,
    input  logic [ehwc_pkg::CH_W-1:0]         ch,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [ehwc_pkg::STATUS_W-1:0]     out_status,
    output logic [ehwc_pkg::SLOT_W-1:0]       out_slot,
    output logic [ehwc_pkg::COUNT_W-1:0]      out_count
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int LW  = $clog2(MAX_LEN + 2);
    localparam int SW  = ehwc_pkg::CFG_W;
    localparam int CW  = ((AW > SW) ? AW : SW) + 1;
    localparam int HW  = ehwc_pkg::HASH_W;
    localparam int NW  = ehwc_pkg::COUNT_W;
    localparam int XW  = ehwc_pkg::CH_W * MAX_LEN;
    localparam int RW  = 1 + NW + LW + XW;
    localparam int DIV_CW = ehwc_pkg::DIV_CNT_W;

    logic [LW-1:0]   word_len_reg;
    logic [HW-1:0]   hash_reg;
    logic [ehwc_pkg::CH_W-1:0] word_chars_reg [MAX_LEN];
    logic [XW-1:0]   word_flat;
    logic [31:0]     fold_sum;
    logic [HW-1:0]   hash_next;
    logic            byte_keep;

    logic [HW-1:0]   dvd_reg;
    logic [SW-1:0]   rem_reg;
    logic [SW-1:0]   size_reg;
    logic [SW-1:0]   size_next;
    logic [SW-1:0]   size_min1;
    logic [DIV_CW-1:0] div_cnt_reg;
    logic [SW:0]     trial;
    logic [SW:0]     trial_diff;
    logic [SW-1:0]   rem_next;

    logic [AW-1:0]   slot_reg;
    logic [SW-1:0]   pc_reg;
    logic [AW-1:0]   clr_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [RW-1:0]   ram_wdata;
    logic [RW-1:0]   ram_rdata;

    logic            row_used;
    logic [NW-1:0]   row_count;
    logic [LW-1:0]   row_len;
    logic [XW-1:0]   row_chars;
    logic [MAX_LEN-1:0] lane_ok;
    logic            slot_free;
    logic            slot_hit;
    logic            probe_last;
    logic [NW-1:0]   new_count;
    logic            slot_wrap;

    ehwc_pkg::status_t pend_status_reg;
    logic [AW-1:0]   pend_slot_reg;
    logic [NW-1:0]   pend_count_reg;

    logic            out_valid_reg;
    ehwc_pkg::status_t out_status_reg;
    logic [AW-1:0]   out_slot_reg;
    logic [NW-1:0]   out_count_reg;

    // ELF fold: shift in the byte, fold the top nibble back and clear it
    always_comb
    begin
        fold_sum  = {hash_reg, 4'b0000} + 32'(ch);
        hash_next = {fold_sum[27:8], fold_sum[7:4] ^ fold_sum[31:28], fold_sum[3:0]};
        byte_keep = (ch != '0) && (word_len_reg <= LW'(MAX_LEN));
        for (int i = 0; i < MAX_LEN; i++)
        begin
            word_flat[i*ehwc_pkg::CH_W +: ehwc_pkg::CH_W] = word_chars_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_len_reg <= '0;
            hash_reg     <= '0;
        end
        else if (cmd.word_clear)
        begin
            word_len_reg <= '0;
            hash_reg     <= '0;
        end
        else if (cmd.byte_take && byte_keep)
        begin
            word_len_reg <= word_len_reg + 1'b1;
            if (word_len_reg < LW'(MAX_LEN))
            begin
                hash_reg <= hash_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            if (cmd.byte_take && byte_keep && (word_len_reg == LW'(i)))
            begin
                word_chars_reg[i] <= ch;
            end
        end
    end

    // Effective table size: zero acts as one, clamp to the table depth
    always_comb
    begin
        size_min1 = (table_size == '0) ? SW'(1) : table_size;
        if (CW'(size_min1) > CW'(TABLE_DEPTH))
        begin
            size_next = SW'(TABLE_DEPTH);
        end
        else
        begin
            size_next = size_min1;
        end
        trial      = {rem_reg, dvd_reg[HW-1]};
        trial_diff = trial - {1'b0, size_reg};
        rem_next   = (trial >= {1'b0, size_reg}) ? trial_diff[SW-1:0] : trial[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg  <= hash_reg;
            rem_reg  <= '0;
            size_reg <= size_next;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[HW-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    // Probe walk
    always_comb
    begin
        row_used  = ram_rdata[RW-1];
        row_count = ram_rdata[RW-2 -: NW];
        row_len   = ram_rdata[RW-2-NW -: LW];
        row_chars = ram_rdata[XW-1:0];
        for (int i = 0; i < MAX_LEN; i++)
        begin
            lane_ok[i] = (LW'(i) >= word_len_reg)
                || (row_chars[i*ehwc_pkg::CH_W +: ehwc_pkg::CH_W] == word_chars_reg[i]);
        end
        slot_free  = !row_used;
        slot_hit   = row_used && (row_len == word_len_reg) && (&lane_ok);
        probe_last = (SW'(pc_reg + 1'b1) == size_reg);
        new_count  = (row_count == ehwc_pkg::COUNT_MAX) ? row_count : row_count + 1'b1;
        slot_wrap  = ((CW'(slot_reg) + CW'(1)) == CW'(size_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_load)
        begin
            slot_reg <= AW'(rem_reg);
            pc_reg   <= '0;
        end
        else if (cmd.probe_eval && !slot_free && !slot_hit)
        begin
            slot_reg <= slot_wrap ? '0 : slot_reg + 1'b1;
            pc_reg   <= pc_reg + 1'b1;
        end
    end

    always_comb
    begin
        ram_we    = cmd.clear_step || (cmd.probe_eval && (slot_free || slot_hit));
        ram_waddr = cmd.clear_step ? clr_reg : slot_reg;
        if (cmd.clear_step)
        begin
            ram_wdata = '0;
        end
        else if (slot_free)
        begin
            ram_wdata = {1'b1, NW'(1), word_len_reg, word_flat};
        end
        else
        begin
            ram_wdata = {1'b1, new_count, row_len, row_chars};
        end
    end

    ehwc_ram #(
        .WIDTH (RW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.probe_read),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Pending result and output register
    always_ff @(posedge clk)
    begin
        if (cmd.pend_special)
        begin
            pend_status_reg <= (word_len_reg == '0) ? ehwc_pkg::STAT_EMPTY
                                                    : ehwc_pkg::STAT_TOO_LONG;
            pend_slot_reg   <= '0;
            pend_count_reg  <= '0;
        end
        else if (cmd.probe_eval)
        begin
            if (slot_free)
            begin
                pend_status_reg <= ehwc_pkg::STAT_INSERTED;
                pend_slot_reg   <= slot_reg;
                pend_count_reg  <= NW'(1);
            end
            else if (slot_hit)
            begin
                pend_status_reg <= ehwc_pkg::STAT_COUNTED;
                pend_slot_reg   <= slot_reg;
                pend_count_reg  <= new_count;
            end
            else
            begin
                pend_status_reg <= ehwc_pkg::STAT_FULL;
                pend_slot_reg   <= '0;
                pend_count_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= pend_status_reg;
            out_slot_reg   <= pend_slot_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = ehwc_pkg::SLOT_W'(out_slot_reg);
    assign out_count  = out_count_reg;

    always_comb
    begin
        sts.clear_done = (clr_reg == AW'(TABLE_DEPTH - 1));
        sts.div_done   = (div_cnt_reg == DIV_CW'(ehwc_pkg::DIV_STEPS));
        sts.word_empty = (word_len_reg == '0);
        sts.word_long  = (word_len_reg > LW'(MAX_LEN));
        sts.slot_free  = slot_free;
        sts.slot_hit   = slot_hit;
        sts.probe_last = probe_last;
        sts.out_busy   = out_valid_reg && !out_ready;
    end

`ifndef NO_ASSERTIONS
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_load |-> (rem_reg < size_reg))
        else $error("hash remainder not below table size");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_read |-> (CW'(slot_reg) < CW'(size_reg)))
        else $error("probe slot outside table");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_read |-> (pc_reg < size_reg))
        else $error("probe walk longer than table");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
`endif

endmodule

[hw/rtl/ehwc_ctrl.sv]
// ----------------------------------------------------------------------------
// ehwc_ctrl
// Sequencer: table clear, byte intake, divide, probe walk and result hand-off.
// ----------------------------------------------------------------------------
module ehwc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_ready,
    input  ehwc_pkg::sts_t  sts,
    output ehwc_pkg::cmd_t  cmd
);

    ehwc_pkg::state_t state_reg;
    ehwc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ehwc_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ehwc_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ehwc_pkg::S_IDLE;
                end
            end
            ehwc_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.byte_take = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ehwc_pkg::S_DIV_LOAD;
                end
            end
            ehwc_pkg::S_DIV_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ehwc_pkg::S_DIV;
            end
            ehwc_pkg::S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ehwc_pkg::S_CHECK;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ehwc_pkg::S_CHECK:
            begin
                if (sts.word_empty || sts.word_long)
                begin
                    cmd.pend_special = 1'b1;
                    state_next       = ehwc_pkg::S_DONE;
                end
                else
                begin
                    cmd.probe_load = 1'b1;
                    state_next     = ehwc_pkg::S_PROBE_RD;
                end
            end
            ehwc_pkg::S_PROBE_RD:
            begin
                cmd.probe_read = 1'b1;
                state_next     = ehwc_pkg::S_PROBE_CMP;
            end
            ehwc_pkg::S_PROBE_CMP:
            begin
                cmd.probe_eval = 1'b1;
                if (sts.slot_free || sts.slot_hit || sts.probe_last)
                begin
                    state_next = ehwc_pkg::S_DONE;
                end
                else
                begin
                    state_next = ehwc_pkg::S_PROBE_RD;
                end
            end
            ehwc_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.word_clear = 1'b1;
                    state_next     = ehwc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ehwc_pkg::S_CLEAR;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_close_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ehwc_pkg::S_IDLE && in_valid && in_last)
            |=> (state_reg == ehwc_pkg::S_DIV_LOAD))
        else $error("closing byte did not start the divide");

    a_probe_next: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ehwc_pkg::S_PROBE_CMP)
            |=> (state_reg == ehwc_pkg::S_PROBE_RD || state_reg == ehwc_pkg::S_DONE))
        else $error("bad state after probe compare");

    a_no_intake_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ehwc_pkg::S_IDLE) |-> !in_ready)
        else $error("byte taken outside idle");
`endif

endmodule

[bench/elf_hash_word_counter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elf_hash_word_counter_tb
// Self-checking bench for the ELF hash word counter. Byte transactions are
// queued per table_size setting and streamed in with random gaps. Each byte
// is run through a local model of the hash table when it is issued, and every
// result transaction is compared field by field with the oldest expectation.
// The result side stalls at random and once holds off long enough to back the
// block up to its input.
// ----------------------------------------------------------------------------
module elf_hash_word_counter_tb;

    localparam int CH_W       = ehwc_pkg::CH_W;
    localparam int HASH_W     = ehwc_pkg::HASH_W;
    localparam int CFG_W      = ehwc_pkg::CFG_W;
    localparam int SLOT_W     = ehwc_pkg::SLOT_W;
    localparam int COUNT_W    = ehwc_pkg::COUNT_W;
    localparam int PADDR_W    = ehwc_pkg::PADDR_W;
    localparam int PDATA_W    = ehwc_pkg::PDATA_W;
    localparam int TBL_DEPTH  = ehwc_pkg::TABLE_DEPTH_DEF;
    localparam int WORD_MAX   = ehwc_pkg::MAX_LEN_DEF;
    localparam int IDLE_PCT   = 8;
    localparam int STALL_MAX  = 20000;
    localparam int HOLD_LEN   = 400;
    localparam int VOCAB_N    = 40;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } byte_item_t;

    typedef struct packed {
        ehwc_pkg::status_t    status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
    } word_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    ehwc_byte_if   bif();
    ehwc_result_if rif();

    initial
    begin
        bif.valid = 1'b0;
        bif.ch    = '0;
        bif.last  = 1'b0;
        rif.ready = 1'b0;
    end

    elf_hash_word_counter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bif.sink),
        .results (rif.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    byte_item_t   pending_bytes[$];
    word_result_t expected_words[$];

    // Table model
    logic [CFG_W-1:0]   cur_table_size = ehwc_pkg::TABLE_SIZE_RST;
    logic               tbl_used[TBL_DEPTH];
    logic [COUNT_W-1:0] tbl_count[TBL_DEPTH];
    int                 tbl_len[TBL_DEPTH];
    logic [CH_W-1:0]    tbl_chars[TBL_DEPTH][WORD_MAX];
    logic [HASH_W-1:0]  run_hash = '0;
    logic [CH_W-1:0]    cur_chars[WORD_MAX];
    int                 cur_len = 0;

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_no = 0;
    int  stall_cycles = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;

    logic [CH_W-1:0] vocab_chars[VOCAB_N][WORD_MAX];
    int              vocab_len[VOCAB_N];

    initial
    begin
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            tbl_used[i] = 1'b0;
        end
    end

    function automatic logic [HASH_W-1:0] elf_fold(logic [HASH_W-1:0] h,
                                                   logic [CH_W-1:0] c);
        logic [31:0] t;
        logic [31:0] g;
        t = {h, 4'b0000} + 32'(c);
        g = t & 32'hF000_0000;
        if (g != 0)
        begin
            t = t ^ (g >> 24);
        end
        t = t & ~g;
        return t[HASH_W-1:0];
    endfunction

    task automatic add_expected(word_result_t r);
        expected_words.insert(expected_words.size(), r);
    endtask

    task automatic predict_byte(byte_item_t it);
        word_result_t r;
        int size;
        int s;
        int len;
        bit done;
        if (it.ch != 0 && cur_len <= WORD_MAX)
        begin
            if (cur_len < WORD_MAX)
            begin
                cur_chars[cur_len] = it.ch;
                run_hash = elf_fold(run_hash, it.ch);
            end
            cur_len++;
        end
        if (!it.last)
        begin
            return;
        end
        len = cur_len;
        cur_len = 0;
        size = int'(cur_table_size);
        if (size == 0)
        begin
            size = 1;
        end
        if (size > TBL_DEPTH)
        begin
            size = TBL_DEPTH;
        end
        s = int'(run_hash) % size;
        run_hash = '0;
        r.status = ehwc_pkg::STAT_FULL;
        r.slot   = '0;
        r.count  = '0;
        done = 1'b0;
        if (len == 0)
        begin
            r.status = ehwc_pkg::STAT_EMPTY;
            done = 1'b1;
        end
        else if (len > WORD_MAX)
        begin
            r.status = ehwc_pkg::STAT_TOO_LONG;
            done = 1'b1;
        end
        for (int i = 0; i < size && !done; i++)
        begin
            if (!tbl_used[s])
            begin
                tbl_used[s] = 1'b1;
                tbl_count[s] = COUNT_W'(1);
                tbl_len[s] = len;
                for (int j = 0; j < len; j++)
                begin
                    tbl_chars[s][j] = cur_chars[j];
                end
                r.status = ehwc_pkg::STAT_INSERTED;
                r.slot   = SLOT_W'(s);
                r.count  = COUNT_W'(1);
                done = 1'b1;
            end
            else if (tbl_len[s] == len)
            begin
                done = 1'b1;
                for (int j = 0; j < len; j++)
                begin
                    if (tbl_chars[s][j] != cur_chars[j])
                    begin
                        done = 1'b0;
                    end
                end
                if (done)
                begin
                    if (tbl_count[s] != ehwc_pkg::COUNT_MAX)
                    begin
                        tbl_count[s]++;
                    end
                    r.status = ehwc_pkg::STAT_COUNTED;
                    r.slot   = SLOT_W'(s);
                    r.count  = tbl_count[s];
                end
            end
            if (!done)
            begin
                s++;
                if (s >= size)
                begin
                    s = 0;
                end
            end
        end
        add_expected(r);
    endtask

    task automatic queue_byte(logic [CH_W-1:0] c, logic l);
        byte_item_t it;
        it.ch   = c;
        it.last = l;
        pending_bytes.insert(pending_bytes.size(), it);
    endtask

    task automatic push_vocab_word(int idx, bit with_nul);
        bit nul_end;
        nul_end = ($urandom_range(3) == 0);
        for (int j = 0; j < vocab_len[idx]; j++)
        begin
            if (with_nul && $urandom_range(9) == 0)
            begin
                queue_byte(8'h00, 1'b0);
            end
            queue_byte(vocab_chars[idx][j], !nul_end && (j == vocab_len[idx] - 1));
        end
        if (nul_end)
        begin
            queue_byte(8'h00, 1'b1);
        end
    endtask

    task automatic push_random_word(int len);
        for (int j = 0; j < len; j++)
        begin
            queue_byte(8'($urandom_range(255)), j == len - 1);
        end
        if (len == 0)
        begin
            queue_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic push_random_phase(int n_items, int vocab_n);
        int start;
        int pick;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                push_vocab_word($urandom_range(vocab_n - 1), 1'b1);
            end
            else if (pick < 88)
            begin
                push_random_word($urandom_range(1, WORD_MAX));
            end
            else if (pick < 93)
            begin
                queue_byte(8'h00, 1'b1);
            end
            else
            begin
                push_random_word($urandom_range(WORD_MAX + 1, WORD_MAX + 8));
            end
        end
    endtask

    task automatic reg_write(logic [CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ehwc_pkg::REG_TABLE_SIZE, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!pready || prdata !== PDATA_W'(value))
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("register readback: exp %0d, got %0d", value, prdata);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_table_size = value;
    endtask

    task automatic drain_phase();
        while (pending_bytes.size() != 0 || bif.valid || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (60) @(posedge clk);
    endtask

    // Byte driver
    always @(posedge clk or negedge rst_n)
    begin
        byte_item_t it;
        if (!rst_n)
        begin
            bif.valid <= 1'b0;
        end
        else if (!bif.valid || bif.ready)
        begin
            if (pending_bytes.size() > 0 &&
                ((cycle_no > 4000 && cycle_no < 9000) || $urandom_range(99) >= IDLE_PCT))
            begin
                it = pending_bytes.pop_front();
                predict_byte(it);
                bif.ch    <= it.ch;
                bif.last  <= it.last;
                bif.valid <= 1'b1;
            end
            else
            begin
                bif.valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        word_result_t exp_r;
        if (rst_n && rif.valid && rif.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: status=%0d slot=%0d count=%0d",
                             rif.status, rif.slot, rif.count);
                end
            end
            else
            begin
                exp_r = expected_words.pop_front();
                if (rif.status !== exp_r.status || rif.slot !== exp_r.slot ||
                    rif.count !== exp_r.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp status=%0d slot=%0d count=%0d,",
                                 exp_r.status, exp_r.slot, exp_r.count);
                        $display("          got status=%0d slot=%0d count=%0d",
                                 rif.status, rif.slot, rif.count);
                    end
                end
            end
        end
    end

    // Result ready, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rif.ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 30)
        begin
            hold_done <= 1'b1;
            hold_cnt  <= HOLD_LEN;
            rif.ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            rif.ready <= 1'b0;
        end
        else
        begin
            rif.ready <= (cycle_no > 4000 && cycle_no < 9000) ||
                         ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if ((bif.valid && bif.ready) || (rif.valid && rif.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < VOCAB_N; i++)
        begin
            vocab_len[i] = $urandom_range(1, WORD_MAX);
            for (int j = 0; j < WORD_MAX; j++)
            begin
                vocab_chars[i][j] = 8'($urandom_range(1, 255));
            end
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        reg_write(ehwc_pkg::TABLE_SIZE_RST);

        // Directed: empty, extremes, NUL, too long, repeats
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h00, 1'b1);
        for (int j = 0; j < WORD_MAX; j++)
        begin
            queue_byte(8'h7F, j == WORD_MAX - 1);
        end
        push_random_word(WORD_MAX + 1);
        queue_byte(8'h01, 1'b1);
        drain_phase();

        reg_write(CFG_W'(1));
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h42, 1'b1);
        queue_byte(8'h00, 1'b1);
        drain_phase();

        reg_write(CFG_W'(0));
        queue_byte(8'h41, 1'b1);
        queue_byte(8'h43, 1'b1);
        drain_phase();

        reg_write(CFG_W'(2047));
        push_random_phase(250, VOCAB_N);
        drain_phase();

        reg_write(CFG_W'(7));
        push_random_phase(150, 12);
        drain_phase();

        reg_write(CFG_W'(1024));
        push_random_phase(400, VOCAB_N);
        drain_phase();

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
